/* design/dq_pkg.sv */
`timescale 1ns / 1ps

package dq_pkg;

    // Default geometry of the queue.
    localparam int DEFAULT_DEPTH = 16;
    localparam int DEFAULT_WIDTH = 32;

    // Fixed port widths of the transaction fields.
    localparam int CMD_W   = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Request codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Per-cell update controls for one cycle.
    typedef struct packed {
        logic load;        // take the pushed word
        logic from_front;  // take the word of the cell nearer the front
        logic from_back;   // take the word of the cell nearer the back
    } t_cell_ctl;

endpackage

/* design/dq_cell.sv */
`timescale 1ns / 1ps

module dq_cell #(
    parameter int WIDTH = dq_pkg::DEFAULT_WIDTH
) (
    input  logic              i_clk,
    input  dq_pkg::t_cell_ctl i_ctl,
    input  logic [WIDTH-1:0]  i_push_word,
    input  logic [WIDTH-1:0]  i_front_word,
    input  logic [WIDTH-1:0]  i_back_word,
    output logic [WIDTH-1:0]  o_word
);

    logic [WIDTH-1:0] r_word;
    logic [WIDTH-1:0] n_word;

    // Pick the next word: a push, a shift from either neighbor, or hold.
    always_comb begin
        if (i_ctl.load) begin
            n_word = i_push_word;
        end else if (i_ctl.from_front) begin
            n_word = i_front_word;
        end else if (i_ctl.from_back) begin
            n_word = i_back_word;
        end else begin
            n_word = r_word;
        end
    end

    // The stored word is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* design/double_ended_queue.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue built as a row of cells; cell k holds the entry
// at position k from the front, so pushes and pops at the front shift the row.
// Input channel: i_valid with o_stall carries i_cmd, i_push_value and
// i_position. Output channel: o_valid with i_stall carries o_data_out,
// o_count and o_status, one result transaction for every request.
// A request is accepted when i_valid is high and o_stall is low. Its result
// appears in the output register in the next cycle. Throughput is one request
// per cycle while o_stall is low; each request's work is the row update plus
// the read select across the cells into the output register.
// While the receiver holds i_stall with a result waiting, o_stall is raised
// and the pending result is kept unchanged; the input side resumes as soon as
// the result is taken, in that same cycle.
// A push onto a full queue reports full, a pop from an empty queue reports
// empty, and a read at or past the count reports out of range; none of these
// change the contents. Unknown commands leave the contents and the count alone.
// Reset (i_rst_n low, synchronous) empties the queue and clears o_valid.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH,
    parameter int WIDTH = dq_pkg::DEFAULT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [dq_pkg::CMD_W-1:0]   i_cmd,
    input  logic [dq_pkg::DATA_W-1:0]  i_push_value,
    input  logic [dq_pkg::POS_W-1:0]   i_position,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [dq_pkg::DATA_W-1:0]  o_data_out,
    output logic [dq_pkg::COUNT_W-1:0] o_count,
    output logic [dq_pkg::STAT_W-1:0]  o_status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
    localparam int XW = (WIDTH > dq_pkg::DATA_W) ? WIDTH : dq_pkg::DATA_W;
    localparam int OW = (CW > dq_pkg::COUNT_W) ? CW : dq_pkg::COUNT_W;

    logic                  accept;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [WIDTH-1:0]      r_out_data;
    logic [WIDTH-1:0]      n_out_data;
    logic [CW-1:0]         r_out_count;
    dq_pkg::t_status       r_out_status;
    dq_pkg::t_status       n_status;

    logic                  is_full;
    logic                  is_empty;
    logic                  pos_ok;
    logic                  do_push_front;
    logic                  do_push_back;
    logic                  do_pop_front;
    logic                  do_pop_back;
    logic [IW-1:0]         sel_idx;
    logic [CW-1:0]         count_less;
    logic [XW-1:0]         push_ext;
    logic [WIDTH-1:0]      push_word;
    logic [WIDTH-1:0]      sel_word;
    logic [XW-1:0]         out_ext;
    logic [OW-1:0]         count_ext;

    dq_pkg::t_cell_ctl     cell_ctl [DEPTH];
    logic [WIDTH-1:0]      cell_word [DEPTH];

    // The input side waits only while a result is held by the receiver.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Decode the request against the current fill level.
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign pos_ok     = (PW'(i_position) < PW'(r_count));
    assign count_less = r_count - CW'(1);

    assign do_push_front = accept && (i_cmd == dq_pkg::CMD_PUSH_FRONT) && !is_full;
    assign do_push_back  = accept && (i_cmd == dq_pkg::CMD_PUSH_BACK) && !is_full;
    assign do_pop_front  = accept && (i_cmd == dq_pkg::CMD_POP_FRONT) && !is_empty;
    assign do_pop_back   = accept && (i_cmd == dq_pkg::CMD_POP_BACK) && !is_empty;

    // Pushed words are cut to the stored width.
    assign push_ext  = XW'(i_push_value);
    assign push_word = push_ext[WIDTH-1:0];

    // Cell to read: the first cell for a pop at the front, the last entry for
    // a pop at the back, else the position.
    always_comb begin
        if (i_cmd == dq_pkg::CMD_POP_FRONT) begin
            sel_idx = '0;
        end else if (i_cmd == dq_pkg::CMD_POP_BACK) begin
            sel_idx = count_less[IW-1:0];
        end else begin
            sel_idx = IW'(i_position);
        end
    end

    // Per-cell controls: a front push shifts the row back, a front pop shifts
    // it forward, and a back push loads the first free cell.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_ctl[k].load       = (do_push_front && (k == 0)) ||
                                     (do_push_back && (r_count == CW'(k)));
            cell_ctl[k].from_front = do_push_front && (k != 0);
            cell_ctl[k].from_back  = do_pop_front && (k != DEPTH - 1);
        end
    end

    // The row of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] front_word;
        logic [WIDTH-1:0] back_word;

        if (g == 0) begin : g_first
            assign front_word = push_word;
        end else begin : g_mid_front
            assign front_word = cell_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign back_word = cell_word[g];
        end else begin : g_mid_back
            assign back_word = cell_word[g+1];
        end

        dq_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_push_word (push_word),
            .i_front_word(front_word),
            .i_back_word (back_word),
            .o_word      (cell_word[g])
        );
    end

    // Each cell drives the read bus only when it is the selected one.
    always_comb begin
        sel_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel_word = sel_word | (cell_word[k] & {WIDTH{sel_idx == IW'(k)}});
        end
    end

    // Next count, result data and status.
    always_comb begin
        n_count    = r_count;
        n_out_data = '0;
        n_status   = dq_pkg::ST_OK;
        case (i_cmd)
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_count    = count_less;
                    n_out_data = sel_word;
                end
            end
            dq_pkg::CMD_READ: begin
                if (pos_ok) begin
                    n_out_data = sel_word;
                end else begin
                    n_status = dq_pkg::ST_RANGE;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control state: fill level and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data   <= n_out_data;
            r_out_count  <= n_count;
            r_out_status <= n_status;
        end
    end

    assign out_ext    = XW'(r_out_data);
    assign count_ext  = OW'(r_out_count);
    assign o_valid    = r_out_valid;
    assign o_data_out = out_ext[dq_pkg::DATA_W-1:0];
    assign o_count    = count_ext[dq_pkg::COUNT_W-1:0];
    assign o_status   = r_out_status;

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // A refused push reports full on the next result.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_full && (i_cmd == dq_pkg::CMD_PUSH_FRONT ||
                               i_cmd == dq_pkg::CMD_PUSH_BACK))
        |=> (o_valid && o_status == dq_pkg::ST_FULL && r_count == $past(r_count)))
        else $error("push on full queue not refused");

    // A successful pop lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop_front || do_pop_back) |=> (r_count == $past(count_less)))
        else $error("pop did not lower the count");

    // Any error result carries zero data.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != dq_pkg::ST_OK) |-> (o_data_out == '0))
        else $error("error result with nonzero data");

endmodule

/* test/double_ended_queue_test.sv */
`timescale 1ns / 1ps

module double_ended_queue_test;

    localparam int DEPTH       = dq_pkg::DEFAULT_DEPTH;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 5;

    // Command codes outside the defined set; the block must ignore them.
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // Burst shapes of the random part.
    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED,
        BURST_NOISE
    } t_burst_kind;

    typedef struct packed {
        logic [dq_pkg::DATA_W-1:0]  data;
        logic [dq_pkg::COUNT_W-1:0] count;
        dq_pkg::t_status            status;
    } t_dq_result;

    typedef struct packed {
        logic [dq_pkg::CMD_W-1:0]  cmd;
        logic [dq_pkg::DATA_W-1:0] value;
        logic [dq_pkg::POS_W-1:0]  pos;
        logic                      has_result;
        t_dq_result                result;
    } t_dq_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [dq_pkg::CMD_W-1:0]   i_cmd;
    logic [dq_pkg::DATA_W-1:0]  i_push_value;
    logic [dq_pkg::POS_W-1:0]   i_position;
    logic                       o_valid;
    logic                       i_stall;
    logic [dq_pkg::DATA_W-1:0]  o_data_out;
    logic [dq_pkg::COUNT_W-1:0] o_count;
    logic [dq_pkg::STAT_W-1:0]  o_status;

    // Shadow copy of the deque contents.
    logic [dq_pkg::DATA_W-1:0]  shadow_words [DEPTH];
    logic [dq_pkg::POS_W-1:0]   shadow_head;
    logic [dq_pkg::COUNT_W-1:0] shadow_count;

    t_dq_result pending_results [$];
    t_dq_row    directed_rows [$];

    // Typed result that goes with the transaction currently on the input.
    logic       row_has_result;
    t_dq_result row_result;

    int failures;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    double_ended_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_out   (o_data_out),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow deque and return the result it gives.
    function automatic t_dq_result deque_apply(input logic [dq_pkg::CMD_W-1:0] cmd,
                                               input logic [dq_pkg::DATA_W-1:0] value,
                                               input logic [dq_pkg::POS_W-1:0] pos);
        t_dq_result res;
        res.data   = '0;
        res.status = dq_pkg::ST_OK;
        case (cmd)
            dq_pkg::CMD_PUSH_FRONT: begin
                if (shadow_count >= dq_pkg::COUNT_W'(DEPTH)) begin
                    res.status = dq_pkg::ST_FULL;
                end else begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_words[shadow_head] = value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            dq_pkg::CMD_PUSH_BACK: begin
                if (shadow_count >= dq_pkg::COUNT_W'(DEPTH)) begin
                    res.status = dq_pkg::ST_FULL;
                end else begin
                    shadow_words[shadow_head + shadow_count[dq_pkg::POS_W-1:0]] = value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (shadow_count == '0) begin
                    res.status = dq_pkg::ST_EMPTY;
                end else begin
                    res.data = shadow_words[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (shadow_count == '0) begin
                    res.status = dq_pkg::ST_EMPTY;
                end else begin
                    shadow_count = shadow_count - 1'b1;
                    res.data = shadow_words[shadow_head + shadow_count[dq_pkg::POS_W-1:0]];
                end
            end
            dq_pkg::CMD_READ: begin
                if (dq_pkg::COUNT_W'(pos) >= shadow_count) begin
                    res.status = dq_pkg::ST_RANGE;
                end else begin
                    res.data = shadow_words[shadow_head + pos];
                end
            end
            default: begin
            end
        endcase
        res.count = shadow_count;
        return res;
    endfunction

    // Predict on every accepted request and check every delivered result.
    always @(posedge i_clk) begin
        t_dq_result want;
        t_dq_result predicted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no request pending: data %h count %0d",
                           o_data_out, o_count);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_data_out !== want.data) begin
                        $error("data_out: expected %h, actual %h", want.data, o_data_out);
                        failures++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, o_count);
                        failures++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        failures++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                predicted = deque_apply(i_cmd, i_push_value, i_position);
                if (row_has_result) begin
                    pending_results.push_back(row_result);
                end else begin
                    pending_results.push_back(predicted);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("double_ended_queue test failed");
            $finish;
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    task automatic add_row(input logic [dq_pkg::CMD_W-1:0] cmd,
                           input logic [dq_pkg::DATA_W-1:0] value,
                           input logic [dq_pkg::POS_W-1:0] pos, input logic has_result,
                           input logic [dq_pkg::DATA_W-1:0] data,
                           input logic [dq_pkg::COUNT_W-1:0] count,
                           input dq_pkg::t_status status);
        t_dq_row row;
        row.cmd        = cmd;
        row.value      = value;
        row.pos        = pos;
        row.has_result = has_result;
        row.result     = '{data: data, count: count, status: status};
        directed_rows.push_back(row);
    endtask

    // Present one request, starting and ending at a falling edge.
    task automatic send_request(input logic [dq_pkg::CMD_W-1:0] cmd,
                                input logic [dq_pkg::DATA_W-1:0] value,
                                input logic [dq_pkg::POS_W-1:0] pos, input logic has_result,
                                input t_dq_result result);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_cmd          = cmd;
        i_push_value   = value;
        i_position     = pos;
        row_has_result = has_result;
        row_result     = result;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Hold the input idle until every predicted result has come back.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom;
    endfunction

    // Position inside the current count most of the time, anything otherwise.
    function automatic logic [dq_pkg::POS_W-1:0] pick_position();
        if (shadow_count != '0 && $urandom_range(3) != 0) begin
            return dq_pkg::POS_W'($urandom_range(int'(shadow_count) - 1));
        end
        return dq_pkg::POS_W'($urandom);
    endfunction

    // Random bursts: fill to full, drain to empty, mixed traffic and noise.
    task automatic run_random(input int n_items);
        int          sent;
        int          extra;
        int          len;
        t_burst_kind kind;
        logic [dq_pkg::CMD_W-1:0] cmd;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1, 2: kind = BURST_FILL;
                3, 4, 5: kind = BURST_DRAIN;
                9:       kind = BURST_NOISE;
                default: kind = BURST_MIXED;
            endcase
            extra = $urandom_range(2);
            len   = $urandom_range(20, 1);
            while (sent < n_items && len > 0) begin
                case (kind)
                    BURST_FILL: begin
                        if ($urandom_range(3) == 0) begin
                            cmd = dq_pkg::CMD_READ;
                        end else begin
                            cmd = $urandom_range(1) ? dq_pkg::CMD_PUSH_FRONT
                                                    : dq_pkg::CMD_PUSH_BACK;
                        end
                        if (shadow_count == dq_pkg::COUNT_W'(DEPTH)) begin
                            if (extra == 0) len = 0;
                            extra--;
                        end
                    end
                    BURST_DRAIN: begin
                        if ($urandom_range(3) == 0) begin
                            cmd = dq_pkg::CMD_READ;
                        end else begin
                            cmd = $urandom_range(1) ? dq_pkg::CMD_POP_FRONT
                                                    : dq_pkg::CMD_POP_BACK;
                        end
                        if (shadow_count == '0) begin
                            if (extra == 0) len = 0;
                            extra--;
                        end
                    end
                    BURST_NOISE: begin
                        cmd = dq_pkg::CMD_W'($urandom_range(7));
                        len--;
                    end
                    default: begin
                        cmd = dq_pkg::CMD_W'($urandom_range(4));
                        len--;
                    end
                endcase
                if (kind == BURST_NOISE) begin
                    send_request(cmd, pick_value(), dq_pkg::POS_W'($urandom), 1'b0, '0);
                end else begin
                    send_request(cmd, pick_value(), pick_position(), 1'b0, '0);
                end
                if (cmd <= dq_pkg::CMD_READ) sent++;
            end
        end
    endtask

    // Main sequence: reset, directed table, then three random phases.
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = dq_pkg::CMD_PUSH_FRONT;
        i_push_value   = '0;
        i_position     = '0;
        i_stall        = 1'b0;
        row_has_result = 1'b0;
        row_result     = '0;
        failures       = 0;
        idle_cycles    = 0;
        send_idle_pct  = 16;
        recv_stall_pct = 70;
        shadow_head    = '0;
        shadow_count   = '0;
        for (int k = 0; k < DEPTH; k++) shadow_words[k] = '0;

        // Empty queue errors, spare commands, word extremes and range checks.
        add_row(dq_pkg::CMD_POP_FRONT,  '0, '0,    1'b1, '0, 5'd0, dq_pkg::ST_EMPTY);
        add_row(dq_pkg::CMD_POP_BACK,   '1, '1,    1'b1, '0, 5'd0, dq_pkg::ST_EMPTY);
        add_row(dq_pkg::CMD_READ,       '0, 4'd0,  1'b1, '0, 5'd0, dq_pkg::ST_RANGE);
        add_row(CMD_SPARE_5,            '1, '1,    1'b1, '0, 5'd0, dq_pkg::ST_OK);
        add_row(CMD_SPARE_7,            '0, '0,    1'b1, '0, 5'd0, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_PUSH_BACK,  '1, '0,    1'b1, '0, 5'd1, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_PUSH_FRONT, '0, '1,    1'b1, '0, 5'd2, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_READ,       '0, 4'd0,  1'b0, '0, 5'd0, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_READ,       '1, 4'd1,  1'b0, '0, 5'd0, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_READ,       '0, 4'd15, 1'b1, '0, 5'd2, dq_pkg::ST_RANGE);
        add_row(CMD_SPARE_6,            '1, '0,    1'b1, '0, 5'd2, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_PUSH_FRONT, 32'h5a5a_a5a5, '0, 1'b1, '0, 5'd3, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_POP_BACK,   '0, '0,    1'b0, '0, 5'd0, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_POP_FRONT,  '0, '0,    1'b0, '0, 5'd0, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_POP_FRONT,  '0, '0,    1'b0, '0, 5'd0, dq_pkg::ST_OK);
        add_row(dq_pkg::CMD_POP_FRONT,  '0, '0,    1'b1, '0, 5'd0, dq_pkg::ST_EMPTY);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].cmd, directed_rows[k].value, directed_rows[k].pos,
                         directed_rows[k].has_result, directed_rows[k].result);
        end
        wait_drained();

        // Busy sender, slow receiver.
        run_random(570);
        wait_drained();

        // Slow sender, busy receiver.
        send_idle_pct  = 70;
        recv_stall_pct = 16;
        run_random(570);
        wait_drained();

        // Back to back in both directions.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(570);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("double_ended_queue test passed");
        end else begin
            $display("double_ended_queue test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue.sv
test/double_ended_queue_test.sv
